// ----- design/qld_pkg.sv -----
package qld_pkg;

  localparam int COMP_W           = 16;
  localparam int FRAC_IN          = COMP_W - 2;
  localparam int FRAC_OUT         = COMP_W - 4;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int TOL_W            = 15;

  typedef logic signed [COMP_W-1:0] comp_t;

  typedef struct packed {
    comp_t first_w;
    comp_t first_x;
    comp_t first_y;
    comp_t first_z;
    comp_t second_w;
    comp_t second_x;
    comp_t second_y;
    comp_t second_z;
  } in_word_t;

  typedef struct packed {
    comp_t rot_x;
    comp_t rot_y;
    comp_t rot_z;
    logic  near_identity;
  } out_word_t;

  // atan(2^-i) in Q.30 radians
  function automatic logic [29:0] atan_q30(input int unsigned i);
    logic [29:0] a;
    case (i)
      0:  a = 30'd843314857;
      1:  a = 30'd497837829;
      2:  a = 30'd263043837;
      3:  a = 30'd133525159;
      4:  a = 30'd67021687;
      5:  a = 30'd33543516;
      6:  a = 30'd16775851;
      7:  a = 30'd8388437;
      8:  a = 30'd4194283;
      9:  a = 30'd2097149;
      10: a = 30'd1048576;
      11: a = 30'd524288;
      12: a = 30'd262144;
      13: a = 30'd131072;
      14: a = 30'd65536;
      15: a = 30'd32768;
      16: a = 30'd16384;
      17: a = 30'd8192;
      18: a = 30'd4096;
      19: a = 30'd2048;
      20: a = 30'd1024;
      21: a = 30'd512;
      22: a = 30'd256;
      23: a = 30'd128;
      24: a = 30'd64;
      25: a = 30'd32;
      26: a = 30'd16;
      27: a = 30'd8;
      28: a = 30'd4;
      29: a = 30'd2;
      30: a = 30'd1;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// ----- design/quaternion_log_difference.sv -----
// Logarithm of the relative rotation of two quaternions. Each input word holds
// quaternions a and b (Q1.14); b is flipped when a.b is negative, d = a*conj(b)
// is formed, its scalar clamped to [-1,1] and the vector norm taken. Above
// the tolerance register (tol_r) the result is 2*atan2(norm,scalar)*v/norm in
// Q3.12, otherwise zeros with near_identity set. The block takes one word per
// clock while in_stall is low and returns one result word per input word, in
// order, through the product and sum stages, the bit-per-stage square root,
// the bit-per-stage dividers that form v/norm, a CORDIC quadrant step plus one
// stage per CORDIC iteration, the angle multiply and the rounding into the
// output register. A stall while a result word is held at the output freezes
// the whole pipeline at once.
module quaternion_log_difference #(
  parameter int CORDIC_STEPS = qld_pkg::CORDIC_STEPS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  qld_pkg::in_word_t         in_word,
  output logic                      out_valid,
  input  logic                      out_stall,
  output qld_pkg::out_word_t        out_word,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [qld_pkg::TOL_W-1:0] cfg_data
);

  localparam int CW       = qld_pkg::COMP_W;
  localparam int FI       = qld_pkg::FRAC_IN;
  localparam int NORM_W   = CW;
  localparam int SQ_W     = 2 * CW;
  localparam int SQRT_N   = CW;
  localparam int RATIO_W  = 31;
  localparam int DIV_N    = RATIO_W;
  localparam int XY_W     = 36;
  localparam int ANG_W    = 34;
  localparam int PROD_W   = 63;
  localparam int RND_W    = CW + 1;
  localparam int RND_SH   = 59 - qld_pkg::FRAC_OUT;
  localparam int PRE_SH   = 30 - FI;

  localparam logic signed [21:0]      W_LIM   = 22'sd1 <<< FI;
  localparam logic signed [21:0]      V_LIM   = W_LIM <<< 1;
  localparam logic signed [ANG_W-1:0] HALF_PI = 34'sd1686629713;
  localparam logic [RND_W-1:0]        OMAX    = RND_W'((1 << (CW - 1)) - 1);
  localparam logic [RND_W-1:0]        OMIN_M  = RND_W'(1 << (CW - 1));

  typedef struct packed {
    qld_pkg::comp_t          w;
    logic [2:0]              neg;
    logic [2:0][NORM_W-1:0]  mag;
  } carry_t;

  typedef struct packed {
    logic                    near;
    logic [NORM_W-1:0]       norm;
    qld_pkg::comp_t          w;
    logic [2:0]              neg;
    logic [2:0][NORM_W-1:0]  rem;
    logic [2:0][RATIO_W-1:0] q;
  } div_t;

  typedef struct packed {
    logic                    near;
    logic [2:0]              neg;
    logic [2:0][RATIO_W-1:0] ratio;
    logic signed [XY_W-1:0]  x;
    logic signed [XY_W-1:0]  y;
    logic signed [ANG_W-1:0] z;
  } cor_t;

  typedef struct packed {
    logic                   near;
    logic [2:0]             neg;
    logic [2:0][PROD_W-1:0] p;
  } mul_t;

  function automatic logic signed [19:0] rnd_q(input logic signed [32:0] p);
    logic [32:0] m;
    logic [32:0] s;
    m = p[32] ? 33'(-p) : 33'(p);
    s = m + (33'd1 << (FI - 1));
    return p[32] ? -$signed(20'(s >> FI)) : $signed(20'(s >> FI));
  endfunction

  function automatic logic signed [21:0] clamp22(input logic signed [21:0] v,
                                                 input logic signed [21:0] lim);
    logic signed [21:0] r;
    r = v;
    if (v > lim) r = lim;
    else if (v < -lim) r = -lim;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration and flow control
  // ---------------------------------------------------------------------------
  logic [qld_pkg::TOL_W-1:0] tol_r;
  logic                      en;
  logic                      out_valid_r;
  qld_pkg::out_word_t        out_word_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= qld_pkg::TOL_W'(1);
    end else if (cfg_valid) begin
      tol_r <= cfg_data;
    end
  end

  // Advance every stage together unless a finished word is held at the output.
  assign en        = !out_valid_r || !out_stall;
  assign in_stall  = !en;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // ---------------------------------------------------------------------------
  // Stage 1: register operands, form the dot-product terms
  // ---------------------------------------------------------------------------
  qld_pkg::comp_t           in_a [4];
  qld_pkg::comp_t           in_c [4];
  qld_pkg::comp_t           a1_r [4];
  qld_pkg::comp_t           c1_r [4];
  logic signed [SQ_W-1:0]   dp1_r [4];
  logic                     v1_r;

  always_comb begin
    in_a[0] = in_word.first_w;
    in_a[1] = in_word.first_x;
    in_a[2] = in_word.first_y;
    in_a[3] = in_word.first_z;
    in_c[0] = in_word.second_w;
    in_c[1] = in_word.second_x;
    in_c[2] = in_word.second_y;
    in_c[3] = in_word.second_z;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        a1_r[k]  <= in_a[k];
        c1_r[k]  <= in_c[k];
        dp1_r[k] <= in_a[k] * in_c[k];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: flip b onto the same hemisphere as a
  // ---------------------------------------------------------------------------
  logic signed [SQ_W+1:0] dot;
  logic signed [CW:0]     c2_nxt [4];
  qld_pkg::comp_t         a2_r [4];
  logic signed [CW:0]     c2_r [4];
  logic                   v2_r;

  always_comb begin
    dot = (SQ_W+2)'(dp1_r[0]) + (SQ_W+2)'(dp1_r[1])
        + (SQ_W+2)'(dp1_r[2]) + (SQ_W+2)'(dp1_r[3]);
    for (int k = 0; k < 4; k++) begin
      c2_nxt[k] = dot[SQ_W+1] ? -(CW+1)'(c1_r[k]) : (CW+1)'(c1_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a2_r <= a1_r;
      c2_r <= c2_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: all sixteen cross products; stage 4: round each as Q5.14 to the step of Q1.14
  // ---------------------------------------------------------------------------
  logic signed [32:0] pr3_r [4][4];
  logic signed [19:0] t4_r  [4][4];
  logic               v3_r;
  logic               v4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          pr3_r[i][j] <= 33'(a2_r[i]) * 33'(c2_r[j]);
          t4_r[i][j]  <= rnd_q(pr3_r[i][j]);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: Hamilton product sums and clamps
  // ---------------------------------------------------------------------------
  logic signed [21:0] ws;
  logic signed [21:0] vs [3];
  qld_pkg::comp_t     w5_r;
  logic signed [CW:0] v5_r [3];
  logic               v5v_r;

  always_comb begin
    ws    = 22'(t4_r[0][0]) + 22'(t4_r[1][1]) + 22'(t4_r[2][2]) + 22'(t4_r[3][3]);
    vs[0] = -22'(t4_r[0][1]) + 22'(t4_r[1][0]) - 22'(t4_r[2][3]) + 22'(t4_r[3][2]);
    vs[1] = -22'(t4_r[0][2]) + 22'(t4_r[2][0]) - 22'(t4_r[3][1]) + 22'(t4_r[1][3]);
    vs[2] = -22'(t4_r[0][3]) + 22'(t4_r[3][0]) - 22'(t4_r[1][2]) + 22'(t4_r[2][1]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w5_r <= CW'(clamp22(ws, W_LIM));
      for (int k = 0; k < 3; k++) begin
        v5_r[k] <= (CW+1)'(clamp22(vs[k], V_LIM));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 6: squares, signs and magnitudes; stage 7: sum of squares
  // ---------------------------------------------------------------------------
  logic [30:0]          sq6_r [3];
  carry_t               c6_r;
  carry_t               c6_nxt;
  logic [SQ_W-1:0]      n7_r;
  carry_t               c7_r;
  logic                 v6_r;
  logic                 v7_r;
  logic signed [2*CW+1:0] vsq [3];

  always_comb begin
    c6_nxt.w = w5_r;
    for (int k = 0; k < 3; k++) begin
      vsq[k]        = (2*CW+2)'(v5_r[k]) * (2*CW+2)'(v5_r[k]);
      c6_nxt.neg[k] = v5_r[k][CW];
      c6_nxt.mag[k] = v5_r[k][CW] ? NORM_W'(-v5_r[k]) : NORM_W'(v5_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        sq6_r[k] <= vsq[k][30:0];
      end
      c6_r <= c6_nxt;
      n7_r <= SQ_W'(sq6_r[0]) + SQ_W'(sq6_r[1]) + SQ_W'(sq6_r[2]);
      c7_r <= c6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      v4_r  <= 1'b0;
      v5v_r <= 1'b0;
      v6_r  <= 1'b0;
      v7_r  <= 1'b0;
    end else if (en) begin
      v1_r  <= in_valid;
      v2_r  <= v1_r;
      v3_r  <= v2_r;
      v4_r  <= v3_r;
      v5v_r <= v4_r;
      v6_r  <= v5v_r;
      v7_r  <= v6_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Integer square root, one result bit per stage
  // ---------------------------------------------------------------------------
  logic [SQ_W-1:0] sqn_r [SQRT_N];
  logic [SQ_W-1:0] sqr_r [SQRT_N];
  carry_t          sqc_r [SQRT_N];
  logic [SQRT_N-1:0] sqv_r;

  for (genvar k = 0; k < SQRT_N; k++) begin : g_sqrt
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (SQRT_N - 1 - k));
    logic [SQ_W-1:0] n_in;
    logic [SQ_W-1:0] r_in;
    logic [SQ_W-1:0] t;
    logic [SQ_W-1:0] n_nxt;
    logic [SQ_W-1:0] r_nxt;
    carry_t          c_in;
    logic            v_in;

    always_comb begin
      if (k == 0) begin
        n_in = n7_r;
        r_in = '0;
        c_in = c7_r;
        v_in = v7_r;
      end else begin
        n_in = sqn_r[k-1];
        r_in = sqr_r[k-1];
        c_in = sqc_r[k-1];
        v_in = sqv_r[k-1];
      end
      t = r_in + BIT;
      if (n_in >= t) begin
        n_nxt = n_in - t;
        r_nxt = (r_in >> 1) + BIT;
      end else begin
        n_nxt = n_in;
        r_nxt = r_in >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sqn_r[k] <= n_nxt;
        sqr_r[k] <= r_nxt;
        sqc_r[k] <= c_in;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sqv_r[k] <= 1'b0;
      end else if (en) begin
        sqv_r[k] <= v_in;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tolerance test and |v_k|*2^30/norm, one quotient bit per stage
  // ---------------------------------------------------------------------------
  div_t             dv_r [DIV_N];
  logic [DIV_N-1:0] dvv_r;

  for (genvar k = 0; k < DIV_N; k++) begin : g_div
    div_t d_in;
    div_t d_nxt;
    logic v_in;
    logic [NORM_W:0] rsh [3];
    logic            ge  [3];

    always_comb begin
      if (k == 0) begin
        d_in      = '0;
        d_in.norm = sqr_r[SQRT_N-1][NORM_W-1:0];
        d_in.near = d_in.norm <= NORM_W'(tol_r);
        d_in.w    = sqc_r[SQRT_N-1].w;
        d_in.neg  = sqc_r[SQRT_N-1].neg;
        d_in.rem  = sqc_r[SQRT_N-1].mag;
        v_in      = sqv_r[SQRT_N-1];
      end else begin
        d_in = dv_r[k-1];
        v_in = dvv_r[k-1];
      end
      d_nxt = d_in;
      for (int m = 0; m < 3; m++) begin
        // first stage takes the integer bit, later ones shift in zeros
        rsh[m] = (k == 0) ? {1'b0, d_in.rem[m]} : {d_in.rem[m], 1'b0};
        ge[m]  = rsh[m] >= {1'b0, d_in.norm};
        d_nxt.rem[m] = ge[m] ? NORM_W'(rsh[m] - {1'b0, d_in.norm}) : NORM_W'(rsh[m]);
        d_nxt.q[m][RATIO_W-1-k] = ge[m];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_r[k] <= d_nxt;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dvv_r[k] <= 1'b0;
      end else if (en) begin
        dvv_r[k] <= v_in;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // CORDIC vectoring for atan2(norm, w): quadrant step, then one per iteration
  // ---------------------------------------------------------------------------
  cor_t                    cp_r;
  cor_t                    cp_nxt;
  logic                    cpv_r;
  logic signed [XY_W-1:0]  x0;
  logic signed [XY_W-1:0]  y0;
  cor_t                    cr_r [CORDIC_STEPS];
  logic [CORDIC_STEPS-1:0] crv_r;

  always_comb begin
    x0           = XY_W'(dv_r[DIV_N-1].w) <<< PRE_SH;
    y0           = $signed(XY_W'(dv_r[DIV_N-1].norm) << PRE_SH);
    cp_nxt.near  = dv_r[DIV_N-1].near;
    cp_nxt.neg   = dv_r[DIV_N-1].neg;
    cp_nxt.ratio = dv_r[DIV_N-1].q;
    // rotate a negative scalar by -pi/2 first
    if (x0 < 0) begin
      cp_nxt.x = y0;
      cp_nxt.y = -x0;
      cp_nxt.z = HALF_PI;
    end else begin
      cp_nxt.x = x0;
      cp_nxt.y = y0;
      cp_nxt.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cp_r <= cp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpv_r <= 1'b0;
    end else if (en) begin
      cpv_r <= dvv_r[DIV_N-1];
    end
  end

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
    localparam logic signed [ANG_W-1:0] AT = ANG_W'(qld_pkg::atan_q30(k));
    cor_t c_in;
    cor_t c_nxt;
    logic v_in;
    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;

    always_comb begin
      if (k == 0) begin
        c_in = cp_r;
        v_in = cpv_r;
      end else begin
        c_in = cr_r[k-1];
        v_in = crv_r[k-1];
      end
      dx    = c_in.y >>> k;
      dy    = c_in.x >>> k;
      c_nxt = c_in;
      if (c_in.y > 0) begin
        c_nxt.x = c_in.x + dx;
        c_nxt.y = c_in.y - dy;
        c_nxt.z = c_in.z + AT;
      end else begin
        c_nxt.x = c_in.x - dx;
        c_nxt.y = c_in.y + dy;
        c_nxt.z = c_in.z - AT;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        cr_r[k] <= c_nxt;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        crv_r[k] <= 1'b0;
      end else if (en) begin
        crv_r[k] <= v_in;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Angle times ratio, then round, sign and saturate into the output register
  // ---------------------------------------------------------------------------
  cor_t        cl;
  logic [31:0] angle;
  mul_t        mu_r;
  mul_t        mu_nxt;
  logic        muv_r;

  always_comb begin
    cl          = cr_r[CORDIC_STEPS-1];
    angle       = cl.z[ANG_W-1] ? '0 : cl.z[31:0];
    mu_nxt.near = cl.near;
    mu_nxt.neg  = cl.neg;
    for (int m = 0; m < 3; m++) begin
      mu_nxt.p[m] = PROD_W'(angle) * PROD_W'(cl.ratio[m]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mu_r <= mu_nxt;
    end
  end

  logic [63:0]         rsum [3];
  logic [RND_W-1:0]    rmag [3];
  qld_pkg::comp_t      rot  [3];
  qld_pkg::out_word_t  ow_nxt;

  always_comb begin
    for (int m = 0; m < 3; m++) begin
      rsum[m] = 64'(mu_r.p[m]) + (64'd1 << (RND_SH - 1));
      rmag[m] = rsum[m][RND_SH +: RND_W];
      if (mu_r.near) begin
        rot[m] = '0;
      end else if (mu_r.neg[m]) begin
        rot[m] = (rmag[m] > OMIN_M) ? $signed(CW'(OMIN_M)) : $signed(CW'(-rmag[m]));
      end else begin
        rot[m] = (rmag[m] > OMAX) ? $signed(CW'(OMAX)) : $signed(CW'(rmag[m]));
      end
    end
    ow_nxt.rot_x         = rot[0];
    ow_nxt.rot_y         = rot[1];
    ow_nxt.rot_z         = rot[2];
    ow_nxt.near_identity = mu_r.near;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_word_r <= ow_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      muv_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      muv_r       <= crv_r[CORDIC_STEPS-1];
      out_valid_r <= muv_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_near_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_word_r.near_identity |->
      out_word_r.rot_x == '0 && out_word_r.rot_y == '0 && out_word_r.rot_z == '0)
    else $error("near-identity word carries a non-zero rotation");

  a_rem_below_norm: assert property (@(posedge clk) disable iff (!rst_n)
    dvv_r[DIV_N-1] && !dv_r[DIV_N-1].near |->
      dv_r[DIV_N-1].rem[0] < dv_r[DIV_N-1].norm &&
      dv_r[DIV_N-1].rem[1] < dv_r[DIV_N-1].norm &&
      dv_r[DIV_N-1].rem[2] < dv_r[DIV_N-1].norm)
    else $error("divider remainder not below norm");

  a_ratio_unit: assert property (@(posedge clk) disable iff (!rst_n)
    dvv_r[DIV_N-1] && !dv_r[DIV_N-1].near |->
      dv_r[DIV_N-1].q[0] <= (RATIO_W'(1) << (RATIO_W - 1)) &&
      dv_r[DIV_N-1].q[1] <= (RATIO_W'(1) << (RATIO_W - 1)) &&
      dv_r[DIV_N-1].q[2] <= (RATIO_W'(1) << (RATIO_W - 1)))
    else $error("component ratio exceeds one");

  a_frozen_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(muv_r) && $stable(crv_r) && $stable(dvv_r) && $stable(sqv_r))
    else $error("pipeline valid bits moved while stalled");

endmodule

// ----- bench/quaternion_log_difference_tb.sv -----
module quaternion_log_difference_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 57 + qld_pkg::CORDIC_STEPS_DEF;
  localparam int N_RANDOM = 500;

  typedef struct {
    qld_pkg::in_word_t  word;
    logic               known;    // expected result typed into the table
    qld_pkg::out_word_t result;
  } stim_row_t;

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_stall;
  qld_pkg::in_word_t           in_word;
  logic                        out_valid;
  logic                        out_stall;
  qld_pkg::out_word_t          out_word;
  logic                        cfg_valid;
  logic                        cfg_ready;
  logic [qld_pkg::TOL_W-1:0]   cfg_data;

  logic [qld_pkg::TOL_W-1:0]   tolerance;
  qld_pkg::out_word_t          pending_rot[$];
  stim_row_t                   stim_rows[$];
  int                          error_count;
  int                          words_sent;
  int                          words_checked;
  int                          ident_seen;
  bit                          hold_off_req;
  bit                          stim_done;

  quaternion_log_difference u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("timeout: %0d words sent, %0d checked", words_sent, words_checked);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic longint sat(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // floor shift for signed values (>>> is floor already)
  function automatic longint fsh(longint v, int s);
    return v >>> s;
  endfunction

  // round half away from zero to Q.14
  function automatic longint rnd14(longint p);
    longint m;
    m = p < 0 ? -p : p;
    m = (m + (64'sd1 <<< (qld_pkg::FRAC_IN - 1))) >>> qld_pkg::FRAC_IN;
    return p < 0 ? -m : m;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    for (int i = 31; i >= 0; i--) begin
      b = 64'd1 << (2 * i);
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

  // vectoring CORDIC, angle in Q.30 radians
  function automatic longint vector_angle(longint x, longint y);
    longint z;
    longint t;
    longint dx;
    longint dy;
    z = 0;
    if (x < 0) begin
      t = x;
      x = y;
      y = -t;
      z = 64'sd1686629713;
    end
    for (int i = 0; i < qld_pkg::CORDIC_STEPS_DEF; i++) begin
      dx = fsh(y, i);
      dy = fsh(x, i);
      if (y > 0) begin
        x += dx;
        y -= dy;
        z += longint'(qld_pkg::atan_q30(i));
      end else begin
        x -= dx;
        y += dy;
        z -= longint'(qld_pkg::atan_q30(i));
      end
    end
    return z;
  endfunction

  function automatic qld_pkg::out_word_t log_rotation(qld_pkg::in_word_t w,
                                                      logic [qld_pkg::TOL_W-1:0] tol);
    longint a[4];
    longint c[4];
    longint v[3];
    longint p;
    longint hi;
    longint lo;
    longint s;
    longint ang;
    longint r;
    longint unsigned sq;
    longint unsigned nrm;
    longint unsigned mag;
    longint unsigned ratio;
    longint unsigned prod;
    qld_pkg::out_word_t o;
    a = '{w.first_w, w.first_x, w.first_y, w.first_z};
    c = '{w.second_w, w.second_x, w.second_y, w.second_z};
    hi = 0;
    lo = 0;
    for (int k = 0; k < 4; k++) begin
      p = a[k] * c[k];
      hi += fsh(p, 2);
      lo += p & 3;
    end
    // flip b onto the same hemisphere; a zero dot leaves it alone
    if (hi + (lo >>> 2) < 0)
      for (int k = 0; k < 4; k++) c[k] = -c[k];
    s = rnd14(a[0]*c[0]) + rnd14(a[1]*c[1]) + rnd14(a[2]*c[2]) + rnd14(a[3]*c[3]);
    v[0] = -rnd14(a[0]*c[1]) + rnd14(c[0]*a[1]) - rnd14(a[2]*c[3]) + rnd14(a[3]*c[2]);
    v[1] = -rnd14(a[0]*c[2]) + rnd14(c[0]*a[2]) - rnd14(a[3]*c[1]) + rnd14(a[1]*c[3]);
    v[2] = -rnd14(a[0]*c[3]) + rnd14(c[0]*a[3]) - rnd14(a[1]*c[2]) + rnd14(a[2]*c[1]);
    s = sat(s, -(64'sd1 <<< qld_pkg::FRAC_IN), 64'sd1 <<< qld_pkg::FRAC_IN);
    sq = 0;
    for (int k = 0; k < 3; k++) begin
      v[k] = sat(v[k], -(64'sd2 <<< qld_pkg::FRAC_IN), 64'sd2 <<< qld_pkg::FRAC_IN);
      sq += longint'(v[k] * v[k]);
    end
    nrm = root_floor(sq);
    o = '0;
    if (nrm <= tol) begin
      o.near_identity = 1'b1;
      return o;
    end
    ang = vector_angle(s <<< (30 - qld_pkg::FRAC_IN),
                       longint'(nrm) <<< (30 - qld_pkg::FRAC_IN));
    if (ang < 0) ang = 0;
    for (int k = 0; k < 3; k++) begin
      mag = v[k] < 0 ? -v[k] : v[k];
      ratio = (mag << 30) / nrm;
      prod = 2 * longint'(ang) * ratio;
      prod = (prod + (64'd1 << (59 - qld_pkg::FRAC_OUT))) >> (60 - qld_pkg::FRAC_OUT);
      r = v[k] < 0 ? -longint'(prod) : longint'(prod);
      r = sat(r, -32768, 32767);
      if (k == 0) o.rot_x = qld_pkg::comp_t'(r);
      else if (k == 1) o.rot_y = qld_pkg::comp_t'(r);
      else o.rot_z = qld_pkg::comp_t'(r);
    end
    return o;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t: word %0d %s mismatch: got %0d, want %0d",
             $realtime, words_checked, what, got, want);
    error_count++;
  endtask

  // Checker: compare each accepted result word with the oldest expectation.
  always @(posedge clk) begin
    qld_pkg::out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_rot.size() == 0) begin
        report_mismatch("unexpected word", 0, 0);
      end else begin
        want = pending_rot.pop_front();
        if (out_word.rot_x !== want.rot_x) report_mismatch("rot_x", out_word.rot_x, want.rot_x);
        if (out_word.rot_y !== want.rot_y) report_mismatch("rot_y", out_word.rot_y, want.rot_y);
        if (out_word.rot_z !== want.rot_z) report_mismatch("rot_z", out_word.rot_z, want.rot_z);
        if (out_word.near_identity !== want.near_identity)
          report_mismatch("near_identity", out_word.near_identity, want.near_identity);
        if (want.near_identity) ident_seen++;
      end
      words_checked++;
    end
  end

  // Receiver: random stall per word, plus one long hold-off on request.
  initial begin
    int gap;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_stall <= 1'b1;
        repeat (3 * LATENCY) @(negedge clk);
        hold_off_req = 1'b0;
        out_stall <= 1'b0;
      end else if (out_valid && !out_stall) begin
        // draw the wait for the next word; more than half the time none at all
        gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 4);
        out_stall <= (gap != 0);
        repeat (gap) @(negedge clk);
        if (gap != 0) out_stall <= 1'b0;
      end
    end
  end

  // Offer one word and hold it until accepted; predict at acceptance.
  task automatic send_word(qld_pkg::in_word_t w, logic known, qld_pkg::out_word_t want);
    qld_pkg::out_word_t calc;
    int gap;
    gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_word  <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    calc = log_rotation(w, tolerance);
    if (known && calc !== want)
      report_mismatch("table entry vs predictor", calc, want);
    pending_rot.push_back(calc);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic drain_and_settle();
    in_valid <= 1'b0;
    while (pending_rot.size() != 0) @(negedge clk);
    repeat (LATENCY) @(negedge clk);
  endtask

  task automatic write_tolerance(logic [qld_pkg::TOL_W-1:0] t);
    cfg_data  <= t;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    tolerance = t;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic qld_pkg::comp_t rnd_comp();
    return qld_pkg::comp_t'($urandom_range(0, 65535));
  endfunction

  // Unit quaternion-ish: random direction scaled near magnitude 1.0 in Q1.14.
  function automatic qld_pkg::in_word_t unit_pair(int spread);
    qld_pkg::in_word_t w;
    real q[8];
    real n;
    for (int h = 0; h < 2; h++) begin
      n = 0.0;
      for (int k = 0; k < 4; k++) begin
        q[4*h+k] = real'($urandom_range(0, 2000)) - 1000.0;
        n += q[4*h+k] * q[4*h+k];
      end
      if (n == 0.0) begin q[4*h] = 1.0; n = 1.0; end
      n = $sqrt(n);
      for (int k = 0; k < 4; k++) q[4*h+k] = q[4*h+k] / n * 16383.0;
    end
    // small relative rotations: pull b towards a
    if (spread > 0)
      for (int k = 0; k < 4; k++) q[4+k] = q[k] + (q[4+k] - q[k]) / real'(spread);
    w.first_w  = qld_pkg::comp_t'(longint'(q[0]));
    w.first_x  = qld_pkg::comp_t'(longint'(q[1]));
    w.first_y  = qld_pkg::comp_t'(longint'(q[2]));
    w.first_z  = qld_pkg::comp_t'(longint'(q[3]));
    w.second_w = qld_pkg::comp_t'(longint'(q[4]));
    w.second_x = qld_pkg::comp_t'(longint'(q[5]));
    w.second_y = qld_pkg::comp_t'(longint'(q[6]));
    w.second_z = qld_pkg::comp_t'(longint'(q[7]));
    return w;
  endfunction

  function automatic stim_row_t row(qld_pkg::comp_t aw, qld_pkg::comp_t ax,
                                    qld_pkg::comp_t ay, qld_pkg::comp_t az,
                                    qld_pkg::comp_t bw, qld_pkg::comp_t bx,
                                    qld_pkg::comp_t by, qld_pkg::comp_t bz,
                                    logic known, qld_pkg::out_word_t want);
    stim_row_t r;
    r.word = '{aw, ax, ay, az, bw, bx, by, bz};
    r.known = known;
    r.result = want;
    return r;
  endfunction

  // Stimulus
  initial begin
    qld_pkg::out_word_t ident;
    qld_pkg::out_word_t none;
    qld_pkg::in_word_t w;
    int pick;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_word = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    tolerance = 1;
    error_count = 0;
    words_sent = 0;
    words_checked = 0;
    ident_seen = 0;
    hold_off_req = 1'b0;
    stim_done = 1'b0;
    ident = '0;
    ident.near_identity = 1'b1;
    none = '0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // Directed table; identity-like rows have their result typed in.
    stim_rows.push_back(row(16384, 0, 0, 0, 16384, 0, 0, 0, 1, ident));
    stim_rows.push_back(row(0, 0, 0, 0, 0, 0, 0, 0, 1, ident));
    stim_rows.push_back(row(16384, 0, 0, 0, -16384, 0, 0, 0, 1, ident));
    stim_rows.push_back(row(0, 16384, 0, 0, 0, 16384, 0, 0, 1, ident));
    stim_rows.push_back(row(16384, 0, 0, 0, 0, 16384, 0, 0, 0, none));
    stim_rows.push_back(row(16384, 0, 0, 0, 0, 0, 16384, 0, 0, none));
    stim_rows.push_back(row(16384, 0, 0, 0, 0, 0, 0, 16384, 0, none));
    stim_rows.push_back(row(16384, 0, 0, 0, 11585, 11585, 0, 0, 0, none));
    stim_rows.push_back(row(16384, 0, 0, 0, 11585, -11585, 0, 0, 0, none));
    stim_rows.push_back(row(16384, 0, 0, 0, 16384, 1, 0, 0, 0, none));
    stim_rows.push_back(row(16384, 0, 0, 0, 16384, 2, 0, 0, 0, none));
    stim_rows.push_back(row(32767, 32767, 32767, 32767, -32768, -32768, -32768, -32768,
                            0, none));
    stim_rows.push_back(row(-32768, -32768, -32768, -32768, -32768, -32768, -32768,
                            -32768, 0, none));
    stim_rows.push_back(row(32767, -32768, 32767, -32768, -32768, 32767, -32768, 32767,
                            0, none));
    stim_rows.push_back(row(0, 32767, 0, 0, 0, 0, 32767, 0, 0, none));
    stim_rows.push_back(row(-32768, 0, 0, 0, 0, 0, 0, 32767, 0, none));
    stim_rows.push_back(row(16384, 0, 0, 0, 0, 0, 16384, 16384, 0, none));
    stim_rows.push_back(row(-1, -1, -1, -1, 1, 1, 1, 1, 0, none));
    stim_rows.push_back(row(8192, 8192, 8192, 8192, -8192, 8192, -8192, 8192, 0, none));
    stim_rows.push_back(row(11585, 0, 11585, 0, -11585, 0, 11585, 0, 0, none));
    foreach (stim_rows[i]) send_word(stim_rows[i].word, stim_rows[i].known,
                                     stim_rows[i].result);
    drain_and_settle();

    // Random phases across tolerance settings, extremes included.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: write_tolerance(15'd0);
        1: write_tolerance(15'h7FFF);
        2: write_tolerance(15'd40);
        3: write_tolerance(qld_pkg::TOL_W'($urandom_range(0, 32767)));
        default: write_tolerance(15'd1);
      endcase
      if (ph == 2) hold_off_req = 1'b1;
      for (int i = 0; i < N_RANDOM / 5; i++) begin
        pick = $urandom_range(0, 9);
        if (pick < 5) w = unit_pair(0);
        else if (pick < 8) w = unit_pair($urandom_range(2, 4000));
        else begin
          // raw noise on every bit
          w = {rnd_comp(), rnd_comp(), rnd_comp(), rnd_comp(),
               rnd_comp(), rnd_comp(), rnd_comp(), rnd_comp()};
        end
        send_word(w, 1'b0, none);
      end
      drain_and_settle();
    end
    stim_done = 1'b1;
  end

  // End of run
  initial begin
    wait (stim_done);
    repeat (LATENCY) @(negedge clk);
    $display("Covered %0d words over five tolerance settings, %0d near identity,",
             words_sent, ident_seen);
    $display("with random stalls on both sides and one long output hold-off.");
    if (error_count == 0 && pending_rot.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
